// ===== sv/jacobi_linear_solver_core_assert.svh =====
// Assertion macros used by the solver checker
`ifndef JACOBI_LINEAR_SOLVER_CORE_ASSERT_SVH
`define JACOBI_LINEAR_SOLVER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define JLS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jls assertion failed");

// Next-cycle implication, disabled during reset
`define JLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jls assertion failed");

`endif

// ===== sv/jls_pkg.sv =====
// Types, codes and helpers for the Jacobi linear solver
`default_nettype none
package jls_pkg;

  localparam int MAX_UNKNOWNS_DEF  = 32;
  localparam int FRACTION_BITS_DEF = 32;
  localparam int CFG_DW            = 32;

  typedef enum logic [2:0] {
    ST_CONVERGED = 3'd0,
    ST_LIMIT     = 3'd1,
    ST_NO_ROWS   = 3'd2,
    ST_FEW_ROWS  = 3'd3,
    ST_ZERO_DIAG = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_NUM_UNKNOWNS = 2'd0,
    CFG_MAX_ITER     = 2'd1,
    CFG_TOLERANCE    = 2'd2,
    CFG_DIAG_MIN     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic               kind;
    logic signed [63:0] coefficient;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [4:0]         index;
    logic signed [63:0] solution;
    logic [15:0]        iterations;
    logic               last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK_RD, S_CHK_EV, S_UPD_START, S_UPD_RHS, S_UPD_RD, S_MUL_LD,
    S_MUL, S_ACC, S_DIAG_RD, S_DIV_LD, S_DIV, S_DIV_END, S_CMP_RD, S_CMP_EV,
    S_SWEEP_END, S_EMIT_RD, S_EMIT_WAIT, S_ERR
  } state_t;

  // Magnitude of a two's complement word, as unsigned
  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/jls_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module jls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/jacobi_linear_solver_core.sv =====
// Jacobi solver top level: coefficient load, sequencer and shared arithmetic unit
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready  | jls_pkg::in_item_t (kind, coefficient)
//   out_    | output    | out_valid/out_ready| jls_pkg::out_item_t
//   cfg_    | input     | cfg_we             | cfg_idx, cfg_wdata
//
// A coefficient item is taken whenever the block is idle. A solve holds
// in_ready low until its last result item is loaded; the arithmetic runs on
// the shared 32x32 multiplier (4 passes per product) and the radix-2
// divider (64 steps per unknown).
// Reset (rst_n low, synchronous) restores the register defaults and empties
// the row count; the coefficient RAMs are not cleared. Result items wait in
// one output register; a stalled out_ready holds the sequencer before each item.
`default_nettype none
module jacobi_linear_solver_core #(
  parameter int MAX_UNKNOWNS  = jls_pkg::MAX_UNKNOWNS_DEF,
  parameter int FRACTION_BITS = jls_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jls_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output jls_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  jls_pkg::cfg_idx_t   cfg_idx,
  input  logic [jls_pkg::CFG_DW-1:0] cfg_wdata
);
  import jls_pkg::*;

  localparam int NW = $clog2(MAX_UNKNOWNS + 1);
  localparam int IW = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
  localparam int MD = MAX_UNKNOWNS * MAX_UNKNOWNS;
  localparam int MW = (MD > 1) ? $clog2(MD) : 1;

  // Configuration registers
  logic [5:0]  num_r;
  logic [15:0] max_iter_r;
  logic [31:0] tol_r;
  logic [31:0] dmin_r;

  state_t state_r, state_nxt;

  logic [NW-1:0]   n_r, i_r, j_r, n_eff;
  logic [1:0]      kk_r;
  logic [5:0]      dcnt_r;
  logic [127:0]    acc_r, prod_r;
  logic [63:0]     ma_r, mb_r, dv_r, rem_r, lo_r, q_r, maxd_r;
  logic            psign_r, qneg_r;
  logic [15:0]     iter_r, rows_r;
  logic [5:0]      col_r;
  status_t         st_r;
  logic [MAX_UNKNOWNS-1:0] vld_r;
  logic            cur_rv_r;
  logic            out_valid_r;
  out_item_t       out_item_r;

  // RAM controls
  logic            mat_we, rhs_we, cur_we, nxt_we;
  logic [MW-1:0]   mat_waddr, mat_raddr;
  logic [IW-1:0]   rhs_waddr, rhs_raddr, cur_raddr, ix_i, ix_j;
  logic [63:0]     mat_rd, rhs_rd, cur_rd, nxt_rd, nxt_wdata, cur_val;

  // Datapath flags and values
  logic            in_acc, solve_req, slot_free, i_last, j_end;
  logic            acc_ovf, div_bad, q_bad, diag_bad, conv, lim;
  logic [127:0]    term, sum, pp_sh, m_abs;
  logic [63:0]     pp, d_mag, diff, a_b, c_b, qv;
  logic [64:0]     rs;
  logic            rs_ge;
  logic [16:0]     iter_inc;

  assign ix_i = i_r[IW-1:0];
  assign ix_j = j_r[IW-1:0];

  // Effective unknown count
  always_comb begin
    if (num_r == 6'd0) begin
      n_eff = NW'(1);
    end else if (int'(num_r) > MAX_UNKNOWNS) begin
      n_eff = NW'(MAX_UNKNOWNS);
    end else begin
      n_eff = NW'(num_r);
    end
  end

  jls_ram #(.WIDTH(64), .DEPTH(MD)) u_mat (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(in_item.coefficient),
    .raddr(mat_raddr), .rdata(mat_rd));
  jls_ram #(.WIDTH(64), .DEPTH(MAX_UNKNOWNS)) u_rhs (
    .clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(in_item.coefficient),
    .raddr(rhs_raddr), .rdata(rhs_rd));
  jls_ram #(.WIDTH(64), .DEPTH(MAX_UNKNOWNS)) u_cur (
    .clk(clk), .we(cur_we), .waddr(ix_i), .wdata(nxt_rd),
    .raddr(cur_raddr), .rdata(cur_rd));
  jls_ram #(.WIDTH(64), .DEPTH(MAX_UNKNOWNS)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(ix_i), .wdata(nxt_wdata),
    .raddr(ix_i), .rdata(nxt_rd));

  assign cur_val = cur_rv_r ? cur_rd : 64'd0;

  // Shared arithmetic: partial product, accumulate, divide step, compares
  always_comb begin
    in_acc    = in_valid && in_ready;
    solve_req = in_acc && in_item.kind;
    slot_free = !out_valid_r || out_ready;
    i_last    = ({1'b0, i_r} + 1'b1) == {1'b0, n_r};
    j_end     = (j_r == n_r);
    pp        = 64'(kk_r[1] ? ma_r[63:32] : ma_r[31:0]) *
                64'(kk_r[0] ? mb_r[63:32] : mb_r[31:0]);
    case (kk_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    term      = psign_r ? prod_r : (~prod_r + 128'd1);
    sum       = acc_r + term;
    acc_ovf   = (acc_r[127] == term[127]) && (sum[127] != acc_r[127]);
    d_mag     = mag64(mat_rd);
    m_abs     = acc_r[127] ? (~acc_r + 128'd1) : acc_r;
    div_bad   = (d_mag == 64'd0) || (m_abs[127:64] >= d_mag);
    diag_bad  = (d_mag == 64'd0) || (d_mag < {32'd0, dmin_r});
    rs        = {rem_r, lo_r[63]};
    rs_ge     = rs >= {1'b0, dv_r};
    q_bad     = qneg_r ? (q_r > 64'h8000_0000_0000_0000) : q_r[63];
    qv        = qneg_r ? (~q_r + 64'd1) : q_r;
    a_b       = nxt_rd ^ 64'h8000_0000_0000_0000;
    c_b       = cur_val ^ 64'h8000_0000_0000_0000;
    diff      = (a_b >= c_b) ? (a_b - c_b) : (c_b - a_b);
    iter_inc  = {1'b0, iter_r} + 17'd1;
    conv      = maxd_r < {32'd0, tol_r};
    lim       = iter_inc[15:0] == max_iter_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (solve_req) begin
          if (rows_r == 16'd0 || rows_r < 16'(n_eff)) state_nxt = S_ERR;
          else state_nxt = S_CHK_RD;
        end
      end
      S_CHK_RD:    state_nxt = S_CHK_EV;
      S_CHK_EV: begin
        if (diag_bad) state_nxt = S_ERR;
        else if (i_last) state_nxt = (max_iter_r == 16'd0) ? S_EMIT_RD : S_UPD_START;
        else state_nxt = S_CHK_RD;
      end
      S_UPD_START: state_nxt = S_UPD_RHS;
      S_UPD_RHS:   state_nxt = S_UPD_RD;
      S_UPD_RD: begin
        if (j_end) state_nxt = S_DIAG_RD;
        else if (j_r != i_r) state_nxt = S_MUL_LD;
      end
      S_MUL_LD:    state_nxt = S_MUL;
      S_MUL:       state_nxt = (kk_r == 2'd3) ? S_ACC : S_MUL;
      S_ACC:       state_nxt = acc_ovf ? S_ERR : S_UPD_RD;
      S_DIAG_RD:   state_nxt = S_DIV_LD;
      S_DIV_LD:    state_nxt = div_bad ? S_ERR : S_DIV;
      S_DIV:       state_nxt = (dcnt_r == 6'd63) ? S_DIV_END : S_DIV;
      S_DIV_END: begin
        if (q_bad) state_nxt = S_ERR;
        else state_nxt = i_last ? S_CMP_RD : S_UPD_START;
      end
      S_CMP_RD:    state_nxt = S_CMP_EV;
      S_CMP_EV:    state_nxt = i_last ? S_SWEEP_END : S_CMP_RD;
      S_SWEEP_END: state_nxt = (conv || lim) ? S_EMIT_RD : S_UPD_START;
      S_EMIT_RD:   state_nxt = S_EMIT_WAIT;
      S_EMIT_WAIT: begin
        if (slot_free) state_nxt = i_last ? S_IDLE : S_EMIT_RD;
      end
      S_ERR:       state_nxt = slot_free ? S_IDLE : S_ERR;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // RAM controls and handshake outputs
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    mat_we    = 1'b0;
    rhs_we    = 1'b0;
    mat_waddr = MW'(32'(rows_r) * MAX_UNKNOWNS + 32'(col_r));
    rhs_waddr = rows_r[IW-1:0];
    if (in_acc && !in_item.kind && rows_r < 16'(n_eff)) begin
      if (32'(col_r) >= 32'(n_eff)) rhs_we = 1'b1;
      else mat_we = 1'b1;
    end
    mat_raddr = MW'(32'(ix_i) * MAX_UNKNOWNS +
                    32'((state_r == S_UPD_RD) ? ix_j : ix_i));
    rhs_raddr = ix_i;
    cur_raddr = (state_r == S_UPD_RD) ? ix_j : ix_i;
    cur_we    = (state_r == S_CMP_EV);
    nxt_we    = (state_r == S_DIV_END) && !q_bad;
    nxt_wdata = qv;
    out_valid = out_valid_r;
    out_item  = out_item_r;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r      <= 6'd4;
      max_iter_r <= 16'd1000;
      tol_r      <= 32'd4295;
      dmin_r     <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_NUM_UNKNOWNS: num_r      <= cfg_wdata[5:0];
        CFG_MAX_ITER:     max_iter_r <= cfg_wdata[15:0];
        CFG_TOLERANCE:    tol_r      <= cfg_wdata;
        CFG_DIAG_MIN:     dmin_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= 16'd0;
      col_r       <= 6'd0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Load a new output item, or drop the one just taken
      if ((state_r == S_ERR || state_r == S_EMIT_WAIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // Advance the load position
      if (in_acc && !in_item.kind) begin
        if (32'(col_r) >= 32'(n_eff)) begin
          if (rows_r != 16'hFFFF) rows_r <= rows_r + 16'd1;
          col_r <= 6'd0;
        end else begin
          col_r <= col_r + 6'd1;
        end
      end
      if (solve_req) begin
        rows_r <= 16'd0;
        col_r  <= 6'd0;
        vld_r  <= '0;
      end
      if (state_r == S_CMP_EV) vld_r[ix_i] <= 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cur_rv_r <= vld_r[cur_raddr];
    case (state_r)
      S_IDLE: begin
        n_r    <= n_eff;
        i_r    <= '0;
        iter_r <= 16'd0;
        if (rows_r == 16'd0) st_r <= ST_NO_ROWS;
        else st_r <= ST_FEW_ROWS;
      end
      S_CHK_EV: begin
        if (!diag_bad) begin
          i_r  <= i_last ? '0 : i_r + 1'b1;
          st_r <= ST_LIMIT;
        end else begin
          st_r <= ST_ZERO_DIAG;
        end
      end
      S_UPD_START: j_r <= '0;
      S_UPD_RHS: acc_r <= {{64{rhs_rd[63]}}, rhs_rd} << FRACTION_BITS;
      S_UPD_RD: begin
        if (!j_end && j_r == i_r) j_r <= j_r + 1'b1;
      end
      S_MUL_LD: begin
        ma_r    <= mag64(mat_rd);
        mb_r    <= mag64(cur_val);
        psign_r <= mat_rd[63] ^ cur_val[63];
        prod_r  <= '0;
        kk_r    <= 2'd0;
      end
      S_MUL: begin
        prod_r <= prod_r + pp_sh;
        kk_r   <= kk_r + 2'd1;
      end
      S_ACC: begin
        acc_r <= sum;
        j_r   <= j_r + 1'b1;
        st_r  <= ST_OVERFLOW;
      end
      S_DIV_LD: begin
        dv_r   <= d_mag;
        rem_r  <= m_abs[127:64];
        lo_r   <= m_abs[63:0];
        q_r    <= 64'd0;
        qneg_r <= acc_r[127] ^ mat_rd[63];
        dcnt_r <= 6'd0;
        st_r   <= ST_OVERFLOW;
      end
      S_DIV: begin
        rem_r  <= rs_ge ? 64'(rs - {1'b0, dv_r}) : rs[63:0];
        lo_r   <= {lo_r[62:0], 1'b0};
        q_r    <= {q_r[62:0], rs_ge};
        dcnt_r <= dcnt_r + 6'd1;
      end
      S_DIV_END: begin
        i_r    <= i_last ? '0 : i_r + 1'b1;
        maxd_r <= 64'd0;
      end
      S_CMP_EV: begin
        if (diff > maxd_r) maxd_r <= diff;
        i_r <= i_last ? '0 : i_r + 1'b1;
      end
      S_SWEEP_END: begin
        iter_r <= iter_inc[15:0];
        st_r   <= conv ? ST_CONVERGED : ST_LIMIT;
      end
      S_EMIT_WAIT: begin
        if (slot_free) begin
          out_item_r.status     <= st_r;
          out_item_r.index      <= 5'(ix_i);
          out_item_r.solution   <= cur_val;
          out_item_r.iterations <= iter_r;
          out_item_r.last       <= i_last;
          i_r                   <= i_r + 1'b1;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_item_r.status     <= st_r;
          out_item_r.index      <= 5'd0;
          out_item_r.solution   <= 64'd0;
          out_item_r.iterations <= 16'd0;
          out_item_r.last       <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/jls_checker.sv =====
// Port-level checker for the Jacobi solver, bound to the top level
`default_nettype none
`include "jacobi_linear_solver_core_assert.svh"
module jls_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_valid,
  input wire                     in_ready,
  input wire jls_pkg::in_item_t  in_item,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire jls_pkg::out_item_t out_item
);
  import jls_pkg::*;

  logic err_item;
  assign err_item = out_item.status != ST_CONVERGED && out_item.status != ST_LIMIT;

  // Hold a stalled result item
  `JLS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))
  // A solve request busies the block
  `JLS_ASSERT_NEXT(a_solve_busy, clk, rst_n, in_valid && in_ready && in_item.kind, !in_ready)
  // An error status is a single final item
  `JLS_ASSERT_NOW(a_err_last, clk, rst_n, out_valid && err_item, out_item.last)
  // An error item carries no solution
  `JLS_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && err_item, out_item.solution == 64'd0 && out_item.iterations == 16'd0 && out_item.index == 5'd0)

endmodule

bind jacobi_linear_solver_core jls_checker u_jls_checker (.*);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the Jacobi linear solver core
`default_nettype none
module tb;
  import jls_pkg::*;

  localparam int MAXN       = 32;
  localparam int STALL_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_we;
  cfg_idx_t    cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;

  jacobi_linear_solver_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Solver state mirrored by the predictor
  logic [63:0] coef_mat [MAXN][MAXN];
  logic [63:0] rhs_vec [MAXN];
  logic [63:0] x_cur [MAXN];
  logic [63:0] x_nxt [MAXN];
  int unsigned rows_cnt;
  int unsigned col_pos;
  logic [5:0]  n_reg;
  logic [15:0] iter_reg;
  logic [31:0] tol_reg;
  logic [31:0] dmin_reg;

  out_item_t   solution_q[$];
  int          fail_cnt;
  int          tx_idle;
  int          rx_idle;
  bit          hold_req;
  int          hold_cnt;
  int          quiet_cycles;
  int          sent;

  typedef struct {
    logic        kind;
    logic [63:0] coef;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  dir_row_t dir_tab[20];

  // Clock: period 4
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [63:0] abs_q(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic int eff_count();
    if (n_reg == 0) return 1;
    if (n_reg > MAXN) return MAXN;
    return int'(n_reg);
  endfunction

  // Append one expected item at the tail of the queue
  function automatic void queue_expected(out_item_t r);
    solution_q.insert(solution_q.size(), r);
  endfunction

  function automatic void push_result(status_t st, int idx, logic [63:0] sol, int it, bit last);
    out_item_t r;
    r.status = st;
    r.index = 5'(idx);
    r.solution = sol;
    r.iterations = 16'(it);
    r.last = last;
    queue_expected(r);
  endfunction

  // One Jacobi update of unknown i into x_nxt; returns 0 on overflow or a zero diagonal
  function automatic bit update_unknown(int n, int i);
    logic [127:0] acc, sub, sum, mag;
    logic signed [127:0] prod;
    logic [127:0] quo;
    logic [63:0] d, q;
    bit ovf;
    ovf = 1'b0;
    acc = {{64{rhs_vec[i][63]}}, rhs_vec[i]} << 32;
    for (int j = 0; j < n; j++) begin
      if (j != i) begin
        prod = $signed({{64{coef_mat[i][j][63]}}, coef_mat[i][j]}) *
               $signed({{64{x_cur[j][63]}}, x_cur[j]});
        sub = -prod;
        sum = acc + sub;
        if (acc[127] == sub[127] && sum[127] != acc[127]) ovf = 1'b1;
        acc = sum;
      end
    end
    if (ovf) return 1'b0;
    d = abs_q(coef_mat[i][i]);
    if (d == 0) return 1'b0;
    mag = acc[127] ? -acc : acc;
    if (mag[127:64] >= d) return 1'b0;
    quo = mag / {64'd0, d};
    q = quo[63:0];
    if (acc[127] ^ coef_mat[i][i][63]) begin
      if (q > 64'h8000000000000000) return 1'b0;
      x_nxt[i] = -q;
    end else begin
      if (q[63]) return 1'b0;
      x_nxt[i] = q;
    end
    return 1'b1;
  endfunction

  // Check the loaded rows, run the sweeps and queue the expected items
  function automatic void predict_solve();
    int n;
    int unsigned r;
    int done;
    bit conv;
    logic [63:0] a, b, diff, maxd, d;
    n = eff_count();
    r = rows_cnt;
    rows_cnt = 0;
    col_pos = 0;
    for (int i = 0; i < MAXN; i++) x_cur[i] = 64'd0;
    if (r == 0) begin
      push_result(ST_NO_ROWS, 0, 64'd0, 0, 1'b1);
      return;
    end
    if (r < n) begin
      push_result(ST_FEW_ROWS, 0, 64'd0, 0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      d = abs_q(coef_mat[i][i]);
      if (d == 0 || d < {32'd0, dmin_reg}) begin
        push_result(ST_ZERO_DIAG, 0, 64'd0, 0, 1'b1);
        return;
      end
    end
    done = 0;
    conv = 1'b0;
    for (int it = 0; it < int'(iter_reg) && !conv; it++) begin
      for (int i = 0; i < n; i++) begin
        if (!update_unknown(n, i)) begin
          push_result(ST_OVERFLOW, 0, 64'd0, 0, 1'b1);
          return;
        end
      end
      maxd = 64'd0;
      for (int i = 0; i < n; i++) begin
        a = x_nxt[i] ^ 64'h8000000000000000;
        b = x_cur[i] ^ 64'h8000000000000000;
        diff = (a >= b) ? a - b : b - a;
        if (diff > maxd) maxd = diff;
        x_cur[i] = x_nxt[i];
      end
      done = it + 1;
      if (maxd < {32'd0, tol_reg}) conv = 1'b1;
    end
    for (int i = 0; i < n; i++)
      push_result(conv ? ST_CONVERGED : ST_LIMIT, i, x_cur[i], done, i == n - 1);
  endfunction

  // Advance the predictor by one accepted item
  function automatic void predict_item(in_item_t it);
    int n;
    n = eff_count();
    if (it.kind) begin
      predict_solve();
    end else if (col_pos >= n) begin
      if (rows_cnt < n) rhs_vec[rows_cnt] = it.coefficient;
      if (rows_cnt < 65535) rows_cnt++;
      col_pos = 0;
    end else begin
      if (rows_cnt < n) coef_mat[rows_cnt][col_pos] = it.coefficient;
      col_pos = (col_pos + 1) & 63;
    end
  endfunction

  // Offer one item after a random gap, hold until accepted
  task automatic send(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    int depth;
    while ($urandom_range(99) < tx_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (!in_ready);
    depth = solution_q.size();
    predict_item(it);
    if (typed) begin
      while (solution_q.size() > depth) void'(solution_q.pop_back());
      queue_expected(want);
    end
    sent++;
    @(negedge clk);
  endtask

  task automatic send_coef(logic [63:0] c);
    in_item_t it;
    it.kind = 1'b0;
    it.coefficient = c;
    send(it);
  endtask

  task automatic send_solve();
    in_item_t it;
    it.kind = 1'b1;
    it.coefficient = {$urandom, $urandom};
    send(it);
  endtask

  function automatic logic [63:0] rand_sign(logic [63:0] v);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic logic [63:0] rand_diag(int n);
    return rand_sign((64'(n + 1 + $urandom_range(3)) << 32) | 64'($urandom));
  endfunction

  function automatic logic [63:0] rand_rhs();
    return rand_sign({24'd0, 8'($urandom), 32'($urandom)});
  endfunction

  // Load a row: diagonal-dominant, noise, or with a tiny diagonal
  task automatic send_row(int n, int r, int flavor);
    for (int j = 0; j < n; j++) begin
      if (flavor == 1) send_coef({$urandom, $urandom});
      else if (j != r) send_coef(rand_sign(64'($urandom)));
      else if (flavor == 2)
        send_coef(rand_sign(dmin_reg == 0 ? 64'd0 : 64'($urandom_range(dmin_reg - 1))));
      else send_coef(rand_diag(n));
    end
    send_coef(flavor == 1 ? {$urandom, $urandom} : rand_rhs());
  endtask

  // One load-and-solve sequence; most are well formed
  task automatic gen_solve(int n, bit clean);
    int v, cnt, bad;
    v = clean ? 0 : $urandom_range(99);
    if (v < 65) begin
      for (int r = 0; r < n; r++) send_row(n, r, 0);
      if ($urandom_range(9) == 0) send_row(n, n, 1);
    end else if (v < 72) begin
      for (int r = 0; r < n; r++) send_row(n, r, 1);
    end else if (v < 80) begin
      bad = $urandom_range(n - 1);
      for (int r = 0; r < n; r++) send_row(n, r, r == bad ? 2 : 0);
    end else if (v < 87) begin
      cnt = $urandom_range(n - 1);
      for (int r = 0; r < cnt; r++) send_row(n, r, 0);
      cnt = $urandom_range(n);
      for (int j = 0; j < cnt; j++) send_coef(rand_rhs());
    end else if (v < 93) begin
      cnt = n + 1 + $urandom_range(2);
      for (int r = 0; r < cnt; r++) send_row(n, r, r < n ? 0 : 1);
    end
    send_solve();
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [31:0] v);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_NUM_UNKNOWNS: n_reg = v[5:0];
      CFG_MAX_ITER:     iter_reg = v[15:0];
      CFG_TOLERANCE:    tol_reg = v;
      CFG_DIAG_MIN:     dmin_reg = v;
      default: ;
    endcase
  endtask

  task automatic configure(int n, int it, logic [31:0] tol, logic [31:0] dmin);
    cfg_write(CFG_NUM_UNKNOWNS, 32'(n));
    cfg_write(CFG_MAX_ITER, 32'(it));
    cfg_write(CFG_TOLERANCE, tol);
    cfg_write(CFG_DIAG_MIN, dmin);
  endtask

  // Drop valid and wait for every expected item, then let the block settle
  task automatic drain();
    in_valid = 1'b0;
    while (solution_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Result side: random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 3000;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      out_ready = 1'b0;
      hold_cnt--;
    end else begin
      out_ready = ($urandom_range(99) >= rx_idle);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (solution_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result item: %p", out_item);
      end else begin
        e = solution_q.pop_front();
        if (e.status !== out_item.status || e.index !== out_item.index ||
            e.solution !== out_item.solution || e.iterations !== out_item.iterations ||
            e.last !== out_item.last) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("mismatch: expected %p, got %p", e, out_item);
        end
      end
    end
  end

  // Watchdog: cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** jacobi_linear_solver_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int budget [8];
    int pn [8];
    int pit [8];
    logic [31:0] ptol [8];
    logic [31:0] pdmin [8];
    bit hold_done;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_NUM_UNKNOWNS;
    cfg_wdata = '0;
    hold_req = 1'b0;
    hold_cnt = 0;
    quiet_cycles = 0;
    fail_cnt = 0;
    sent = 0;
    hold_done = 1'b0;
    n_reg = 6'd4;
    iter_reg = 16'd1000;
    tol_reg = 32'd4295;
    dmin_reg = 32'd1;
    rows_cnt = 0;
    col_pos = 0;
    tx_idle = 38;
    rx_idle = 47;

    // Directed rows with one unknown: empty, discarded partial row, zero diagonal,
    // plain solve, extreme coefficients, quotient overflow, extra rows
    dir_tab[0]  = '{1'b1, 64'd0, 1'b1, '{ST_NO_ROWS, 5'd0, 64'sd0, 16'd0, 1'b1}};
    dir_tab[1]  = '{1'b0, 64'd5, 1'b0, '0};
    dir_tab[2]  = '{1'b1, 64'd0, 1'b1, '{ST_NO_ROWS, 5'd0, 64'sd0, 16'd0, 1'b1}};
    dir_tab[3]  = '{1'b0, 64'd0, 1'b0, '0};
    dir_tab[4]  = '{1'b0, 64'd7, 1'b0, '0};
    dir_tab[5]  = '{1'b1, 64'd0, 1'b1, '{ST_ZERO_DIAG, 5'd0, 64'sd0, 16'd0, 1'b1}};
    dir_tab[6]  = '{1'b0, 64'h1_0000_0000, 1'b0, '0};
    dir_tab[7]  = '{1'b0, 64'h3_0000_0000, 1'b0, '0};
    dir_tab[8]  = '{1'b1, 64'd0, 1'b1,
                    '{ST_CONVERGED, 5'd0, 64'sh3_0000_0000, 16'd2, 1'b1}};
    dir_tab[9]  = '{1'b0, 64'h8000000000000000, 1'b0, '0};
    dir_tab[10] = '{1'b0, 64'h7FFFFFFFFFFFFFFF, 1'b0, '0};
    dir_tab[11] = '{1'b1, 64'hFFFFFFFFFFFFFFFF, 1'b0, '0};
    dir_tab[12] = '{1'b0, 64'd1, 1'b0, '0};
    dir_tab[13] = '{1'b0, 64'h7FFFFFFFFFFFFFFF, 1'b0, '0};
    dir_tab[14] = '{1'b1, 64'd0, 1'b1, '{ST_OVERFLOW, 5'd0, 64'sd0, 16'd0, 1'b1}};
    dir_tab[15] = '{1'b0, 64'h2_0000_0000, 1'b0, '0};
    dir_tab[16] = '{1'b0, 64'h4_0000_0000, 1'b0, '0};
    dir_tab[17] = '{1'b0, 64'd9, 1'b0, '0};
    dir_tab[18] = '{1'b0, -64'd9, 1'b0, '0};
    dir_tab[19] = '{1'b1, 64'd0, 1'b0, '0};

    // Settings per random phase: count, sweep limit, tolerance, diagonal minimum
    pn = '{4, 1, 3, 2, 4, 0, 6, 3};
    pit = '{1000, 65535, 0, 1, 20, 30, 2, 40};
    ptol = '{32'd4295, 32'hFFFFFFFF, 32'd4295, 32'd0, 32'd0, 32'd4295, 32'd4295, 32'd1000};
    pdmin = '{32'd1, 32'd0, 32'd1, 32'd1, 32'h80000000, 32'hFFFFFFFF, 32'h10000, 32'd1};
    budget = '{70, 70, 60, 70, 60, 70, 0, 80};

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    configure(1, 1000, 32'd4295, 32'd1);
    foreach (dir_tab[k]) begin
      in_item_t it;
      it.kind = dir_tab[k].kind;
      it.coefficient = dir_tab[k].coef;
      send(it, dir_tab[k].typed, dir_tab[k].want);
    end
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        tx_idle = 38;
        rx_idle = 47;
      end else if (p < 6) begin
        tx_idle = 47;
        rx_idle = 38;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      configure(pn[p], pit[p], ptol[p], pdmin[p]);
      sent = 0;
      if (budget[p] == 0) gen_solve(eff_count(), 1'b1);
      while (sent < budget[p]) begin
        if (p == 0 && !hold_done && sent >= 20) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        gen_solve(eff_count(), 1'b0);
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("** jacobi_linear_solver_core: PASSED **");
    end else begin
      $display("** jacobi_linear_solver_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/jls_pkg.sv
sv/jls_ram.sv
sv/jacobi_linear_solver_core.sv
sv/jls_checker.sv
tb/sv/tb.sv
